### hdl/fevt_pkg.sv
// fevt_pkg: shared constants, types and the severity decode of the fault event table
// no dependencies; imported by fevt_eval, fevt_store, the top level and the bench
package fevt_pkg;

   localparam int ENTRIES = 32;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int KEY_W   = 64;
   localparam int TIME_W  = 32;
   localparam int CNT_W   = 32;
   localparam int SEV_W   = 3;
   localparam int SLOT_W  = 5;
   localparam int TOT_W   = 6;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [KEY_W-1:0]  key_type;
   typedef logic [TIME_W-1:0] time_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [SEV_W-1:0]  sev_type;

   localparam sev_type SEV_NONE    = 3'd0;
   localparam sev_type SEV_INFO    = 3'd1;
   localparam sev_type SEV_WARNING = 3'd2;
   localparam sev_type SEV_ERROR   = 3'd3;
   localparam sev_type SEV_FATAL   = 3'd4;

   localparam logic MODE_REPORT = 1'b0;
   localparam logic MODE_TICK   = 1'b1;

   localparam time_type TTL_DEFAULT = 32'd20000;

   // read request into the table
   typedef struct packed {
      logic    en;
      idx_type idx;
   } rd_req_type;

   // entry write from a report
   typedef struct packed {
      logic     en;
      idx_type  idx;
      key_type  key;
      time_type seen;
      cnt_type  count;
      logic     sev_en;
      sev_type  sev;
   } wr_req_type;

   // active bit clear from a tick
   typedef struct packed {
      logic    en;
      idx_type idx;
   } clr_req_type;

   // registered read data of one entry
   typedef struct packed {
      logic     vld;
      idx_type  idx;
      key_type  key;
      time_type seen;
      cnt_type  count;
      logic     active;
   } rd_data_type;

   typedef struct packed {
      key_type  key;
      key_type  req_key;
      time_type seen;
      time_type now;
      logic     active;
      time_type ttl;
      logic     inact_found;
      time_type inact_age;
      logic     all_found;
      time_type all_age;
   } eval_in_type;

   typedef struct packed {
      logic     key_match;
      logic     key_zero;
      time_type age;
      logic     take_inact;
      logic     take_all;
      logic     expire;
   } eval_out_type;

   function automatic sev_type sev_of(input logic [31:0] code);
      case (code[31:16])
         16'd1:   return SEV_FATAL;
         16'd2:   return SEV_ERROR;
         16'd3:   return SEV_WARNING;
         16'd4:   return SEV_INFO;
         default: return SEV_NONE;
      endcase
   endfunction

endpackage

### hdl/fault_event_table_with_aging_unit.sv
// fault_event_table_with_aging_unit: top level, sequencer and response registers
// depends on fevt_pkg, fevt_eval and fevt_store
//
// A request is taken when start is high and busy is low. Every request
// gives exactly one response, shown for one cycle with rsp_strobe high;
// the receiver cannot stall it, so it must take the response in that
// cycle. A request walks the whole table once, one entry per cycle through
// the single read port of the entry memories and the shared compare unit,
// then passes through a drain state, the write state and the severity and
// active summary state. The strobe follows the summary state, and busy
// falls in the strobe cycle, so the next request is taken at the edge
// that ends the strobe cycle. csr_ready is always high; write ttl
// only while no request is in flight. A ttl of zero selects 20000 ms.
// No clearing pass is needed after reset: valid flops make untouched
// entries read as empty.
module fault_event_table_with_aging_unit (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_mode,
   input  logic [31:0]              req_attr,
   input  logic [31:0]              req_code,
   input  logic [31:0]              req_now_ms,
   // response channel
   output logic                     rsp_strobe,
   output logic [4:0]               rsp_slot,
   output logic                     rsp_new_entry,
   output logic                     rsp_became_active,
   output logic [31:0]              rsp_hit_count,
   output logic [2:0]               rsp_top_severity,
   output logic                     rsp_has_problem,
   output logic [5:0]               rsp_active_total,
   // ttl register write
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [31:0]              csr_data
);
   import fevt_pkg::*;

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DRAIN  = 3'd2;
   localparam logic [2:0] ST_UPDATE = 3'd3;
   localparam logic [2:0] ST_SUM    = 3'd4;

   localparam idx_type LAST_IDX = IDX_W'(ENTRIES - 1);

   logic [2:0] state_ff, state_in;
   idx_type    scan_ff;
   time_type   ttl_ff;
   time_type   ttl_eff;

   // captured request
   logic       mode_ff;
   key_type    key_ff;
   time_type   now_ff;

   // scan results
   logic       match_found_ff;
   idx_type    match_idx_ff;
   cnt_type    match_cnt_ff;
   logic       match_act_ff;
   logic       empty_found_ff;
   idx_type    empty_idx_ff;
   logic       inact_found_ff;
   idx_type    inact_idx_ff;
   time_type   inact_age_ff;
   logic       all_found_ff;
   idx_type    all_idx_ff;
   time_type   all_age_ff;

   // response registers
   logic       rsp_strobe_ff;
   logic [4:0] rsp_slot_ff;
   logic       rsp_new_ff;
   logic       rsp_became_ff;
   cnt_type    rsp_hits_ff;
   sev_type    rsp_top_ff;
   logic       rsp_problem_ff;
   logic [5:0] rsp_total_ff;

   rd_req_type            rd_req;
   wr_req_type            wr_req;
   clr_req_type           clr_req;
   rd_data_type           rd_data;
   logic [ENTRIES-1:0]    active_vec;
   sev_type [ENTRIES-1:0] sev_vec;
   eval_in_type           ev_in;
   eval_out_type          ev_out;

   logic    sel_hit;
   idx_type sel_idx;
   logic    scan_eval;
   sev_type top_sev;
   logic [4:1] sev_any;

   fevt_store u_store (
      .clock      (clock),
      .reset      (reset),
      .rd_req     (rd_req),
      .wr_req     (wr_req),
      .clr_req    (clr_req),
      .rd_data    (rd_data),
      .active_vec (active_vec),
      .sev_vec    (sev_vec)
   );

   fevt_eval u_eval (
      .ev_in  (ev_in),
      .ev_out (ev_out)
   );

   // ttl register, zero means the default
   assign csr_ready = 1'b1;
   assign ttl_eff   = (ttl_ff == '0) ? TTL_DEFAULT : ttl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_ff <= TTL_DEFAULT;
      end else if (csr_valid && csr_ready) begin
         ttl_ff <= csr_data;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (start) state_in = ST_SCAN;
         ST_SCAN:   if (scan_ff == LAST_IDX) state_in = ST_DRAIN;
         ST_DRAIN:  state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_SUM;
         ST_SUM:    state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // one table read per scan cycle
   always_comb begin
      rd_req.en  = (state_ff == ST_SCAN);
      rd_req.idx = scan_ff;
   end

   // read data arrives in the cycle after its request
   assign scan_eval = rd_data.vld;

   always_comb begin
      ev_in.key         = rd_data.key;
      ev_in.req_key     = key_ff;
      ev_in.seen        = rd_data.seen;
      ev_in.now         = now_ff;
      ev_in.active      = rd_data.active;
      ev_in.ttl         = ttl_eff;
      ev_in.inact_found = inact_found_ff;
      ev_in.inact_age   = inact_age_ff;
      ev_in.all_found   = all_found_ff;
      ev_in.all_age     = all_age_ff;
   end

   // tick: expire the entry under evaluation
   always_comb begin
      clr_req.en  = scan_eval && (mode_ff == MODE_TICK) && ev_out.expire;
      clr_req.idx = rd_data.idx;
   end

   // victim choice: match, first empty, oldest inactive, oldest of all
   always_comb begin
      sel_hit = 1'b0;
      if (match_found_ff) begin
         sel_hit = 1'b1;
         sel_idx = match_idx_ff;
      end else if (empty_found_ff) begin
         sel_idx = empty_idx_ff;
      end else if (inact_found_ff) begin
         sel_idx = inact_idx_ff;
      end else begin
         sel_idx = all_idx_ff;
      end
   end

   always_comb begin
      wr_req.en     = (state_ff == ST_UPDATE) && (mode_ff == MODE_REPORT);
      wr_req.idx    = sel_idx;
      wr_req.key    = key_ff;
      wr_req.seen   = now_ff;
      wr_req.count  = sel_hit ? (match_cnt_ff + 32'd1) : 32'd1;
      // a hit keeps the stored severity
      wr_req.sev_en = !sel_hit;
      wr_req.sev    = sev_of(key_ff[31:0]);
   end

   // highest severity among active entries
   always_comb begin
      sev_any = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (active_vec[i]) begin
            if (sev_vec[i] == SEV_INFO)    sev_any[1] = 1'b1;
            if (sev_vec[i] == SEV_WARNING) sev_any[2] = 1'b1;
            if (sev_vec[i] == SEV_ERROR)   sev_any[3] = 1'b1;
            if (sev_vec[i] == SEV_FATAL)   sev_any[4] = 1'b1;
         end
      end
      if (sev_any[4])      top_sev = SEV_FATAL;
      else if (sev_any[3]) top_sev = SEV_ERROR;
      else if (sev_any[2]) top_sev = SEV_WARNING;
      else if (sev_any[1]) top_sev = SEV_INFO;
      else                 top_sev = SEV_NONE;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         scan_ff        <= '0;
         match_found_ff <= 1'b0;
         empty_found_ff <= 1'b0;
         inact_found_ff <= 1'b0;
         all_found_ff   <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= (state_ff == ST_SUM);
         if (state_ff == ST_IDLE && start) begin
            scan_ff        <= '0;
            match_found_ff <= 1'b0;
            empty_found_ff <= 1'b0;
            inact_found_ff <= 1'b0;
            all_found_ff   <= 1'b0;
         end else begin
            if (state_ff == ST_SCAN) begin
               scan_ff <= scan_ff + 1'b1;
            end
            if (scan_eval && mode_ff == MODE_REPORT) begin
               if (ev_out.key_match) match_found_ff <= 1'b1;
               if (ev_out.key_zero)  empty_found_ff <= 1'b1;
               if (ev_out.take_inact) inact_found_ff <= 1'b1;
               all_found_ff <= 1'b1;
            end
         end
      end
   end

   // request capture, scan payload and response payload
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         mode_ff <= req_mode;
         key_ff  <= {req_attr, req_code};
         now_ff  <= req_now_ms;
      end
      if (scan_eval && mode_ff == MODE_REPORT) begin
         // first match and first empty only
         if (ev_out.key_match && !match_found_ff) begin
            match_idx_ff <= rd_data.idx;
            match_cnt_ff <= rd_data.count;
            match_act_ff <= rd_data.active;
         end
         if (ev_out.key_zero && !empty_found_ff) begin
            empty_idx_ff <= rd_data.idx;
         end
         if (ev_out.take_inact) begin
            inact_idx_ff <= rd_data.idx;
            inact_age_ff <= ev_out.age;
         end
         if (ev_out.take_all) begin
            all_idx_ff <= rd_data.idx;
            all_age_ff <= ev_out.age;
         end
      end
      if (state_ff == ST_UPDATE) begin
         if (mode_ff == MODE_REPORT) begin
            rsp_slot_ff   <= SLOT_W'(sel_idx);
            rsp_new_ff    <= !sel_hit;
            // replacing an entry always counts as newly active
            rsp_became_ff <= sel_hit ? !match_act_ff : 1'b1;
            rsp_hits_ff   <= wr_req.count;
         end else begin
            rsp_slot_ff   <= '0;
            rsp_new_ff    <= 1'b0;
            rsp_became_ff <= 1'b0;
            rsp_hits_ff   <= '0;
         end
      end
      if (state_ff == ST_SUM) begin
         rsp_top_ff     <= top_sev;
         rsp_problem_ff <= (top_sev >= SEV_WARNING);
         rsp_total_ff   <= TOT_W'($countones(active_vec));
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_new_entry     = rsp_new_ff;
   assign rsp_became_active = rsp_became_ff;
   assign rsp_hit_count     = rsp_hits_ff;
   assign rsp_top_severity  = rsp_top_ff;
   assign rsp_has_problem   = rsp_problem_ff;
   assign rsp_active_total  = rsp_total_ff;

   // checks
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response strobe while sequencer busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe longer than one cycle");

   a_new_became: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_new_entry) |-> rsp_became_active)
      else $error("new entry not reported as newly active");

   a_tick_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && mode_ff == MODE_TICK) |->
         (rsp_hit_count == '0 && !rsp_new_entry && rsp_slot == '0))
      else $error("tick response carries report fields");

endmodule

### hdl/fevt_eval.sv
// fevt_eval: shared compare unit, applied to one table entry per cycle
// depends on fevt_pkg
module fevt_eval (
   input  fevt_pkg::eval_in_type  ev_in,
   output fevt_pkg::eval_out_type ev_out
);
   import fevt_pkg::*;

   time_type age;

   assign age = ev_in.now - ev_in.seen;

   always_comb begin
      ev_out.age        = age;
      ev_out.key_match  = (ev_in.key == ev_in.req_key);
      ev_out.key_zero   = (ev_in.key == '0);
      // ties go to the later entry, so >= while scanning upward
      ev_out.take_inact = !ev_in.active && (!ev_in.inact_found || (age >= ev_in.inact_age));
      ev_out.take_all   = !ev_in.all_found || (age >= ev_in.all_age);
      ev_out.expire     = !ev_out.key_zero && ev_in.active && (age > ev_in.ttl);
   end

endmodule

### hdl/fevt_store.sv
// fevt_store: entry memories (key, last seen, count) plus valid, active and severity flops
// depends on fevt_pkg
module fevt_store (
   input  logic                                        clock,
   input  logic                                        reset,
   input  fevt_pkg::rd_req_type                        rd_req,
   input  fevt_pkg::wr_req_type                        wr_req,
   input  fevt_pkg::clr_req_type                       clr_req,
   output fevt_pkg::rd_data_type                       rd_data,
   output logic [fevt_pkg::ENTRIES-1:0]                active_vec,
   output fevt_pkg::sev_type [fevt_pkg::ENTRIES-1:0]   sev_vec
);
   import fevt_pkg::*;

   key_type  key_mem   [ENTRIES];
   time_type seen_mem  [ENTRIES];
   cnt_type  count_mem [ENTRIES];

   key_type  key_rd_ff;
   time_type seen_rd_ff;
   cnt_type  count_rd_ff;
   idx_type  rd_idx_ff;
   logic     rd_vld_ff;

   logic [ENTRIES-1:0]            valid_ff;
   logic [ENTRIES-1:0]            active_ff;
   sev_type [ENTRIES-1:0]         sev_ff;

   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         key_mem[wr_req.idx]   <= wr_req.key;
         seen_mem[wr_req.idx]  <= wr_req.seen;
         count_mem[wr_req.idx] <= wr_req.count;
      end
      if (rd_req.en) begin
         key_rd_ff   <= key_mem[rd_req.idx];
         seen_rd_ff  <= seen_mem[rd_req.idx];
         count_rd_ff <= count_mem[rd_req.idx];
         rd_idx_ff   <= rd_req.idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         valid_ff  <= '0;
         active_ff <= '0;
         sev_ff    <= '0;
      end else begin
         rd_vld_ff <= rd_req.en;
         if (wr_req.en) begin
            valid_ff[wr_req.idx]  <= 1'b1;
            active_ff[wr_req.idx] <= 1'b1;
         end
         if (wr_req.en && wr_req.sev_en) begin
            sev_ff[wr_req.idx] <= wr_req.sev;
         end
         if (clr_req.en) begin
            active_ff[clr_req.idx] <= 1'b0;
         end
      end
   end

   // never-written entries read as zero
   always_comb begin
      rd_data.vld    = rd_vld_ff;
      rd_data.idx    = rd_idx_ff;
      rd_data.key    = valid_ff[rd_idx_ff] ? key_rd_ff   : '0;
      rd_data.seen   = valid_ff[rd_idx_ff] ? seen_rd_ff  : '0;
      rd_data.count  = valid_ff[rd_idx_ff] ? count_rd_ff : '0;
      rd_data.active = active_ff[rd_idx_ff];
   end

   assign active_vec = active_ff;
   assign sev_vec    = sev_ff;

endmodule

### bench/tb.sv
// tb: self-checking bench for fault_event_table_with_aging_unit
// holds a scoreboard class that keeps its own copy of the event table and ttl
// depends on fevt_pkg and the RTL under hdl

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fevt_pkg::*;

   // severity field values carried in code[31:16]
   localparam logic [15:0] CODE_FATAL   = 16'd1;
   localparam logic [15:0] CODE_ERROR   = 16'd2;
   localparam logic [15:0] CODE_WARNING = 16'd3;
   localparam logic [15:0] CODE_INFO    = 16'd4;

   // one response as seen on the rsp_ ports, in port order
   typedef struct packed {
      logic [4:0]  slot;
      logic        new_entry;
      logic        became_active;
      logic [31:0] hit_count;
      logic [2:0]  top_severity;
      logic        has_problem;
      logic [5:0]  active_total;
   } fault_status_type;

   // table predictor plus the queue of responses still owed by the block
   class fault_table_scoreboard;
      key_type          key_tbl[ENTRIES];
      sev_type          sev_tbl[ENTRIES];
      time_type         seen_tbl[ENTRIES];
      cnt_type          count_tbl[ENTRIES];
      bit               active_tbl[ENTRIES];
      time_type         ttl;
      fault_status_type expected_q[$];
      int               errors;

      function new();
         for (int i = 0; i < ENTRIES; i++) begin
            key_tbl[i]    = '0;
            sev_tbl[i]    = SEV_NONE;
            seen_tbl[i]   = '0;
            count_tbl[i]  = '0;
            active_tbl[i] = 1'b0;
         end
         ttl    = TTL_DEFAULT;
         errors = 0;
      endfunction

      function void set_ttl(time_type value);
         ttl = value;
      endfunction

      function sev_type severity_of(logic [31:0] code);
         case (code[31:16])
            CODE_FATAL:   return SEV_FATAL;
            CODE_ERROR:   return SEV_ERROR;
            CODE_WARNING: return SEV_WARNING;
            CODE_INFO:    return SEV_INFO;
            default:      return SEV_NONE;
         endcase
      endfunction

      // oldest entry by wrapped age, ties to the higher index; -1 when none qualifies
      function int oldest(time_type now_ms, bit inactive_only);
         int       best;
         time_type best_age;
         time_type age;
         best     = -1;
         best_age = '0;
         for (int i = 0; i < ENTRIES; i++) begin
            if (inactive_only && active_tbl[i])
               continue;
            age = now_ms - seen_tbl[i];
            if (best < 0 || age >= best_age) begin
               best_age = age;
               best     = i;
            end
         end
         return best;
      endfunction

      function void note_request(logic mode, logic [31:0] attr, logic [31:0] code,
                                 time_type now_ms);
         fault_status_type want;
         key_type          key;
         int               slot;
         int               total;
         sev_type          top;
         time_type         limit;
         time_type         age;
         want  = '0;
         total = 0;
         top   = SEV_NONE;
         if (mode == MODE_REPORT) begin
            key  = {attr, code};
            slot = -1;
            // an all-zero key lands on the first empty entry as a hit
            for (int i = 0; i < ENTRIES; i++)
               if (slot < 0 && key_tbl[i] == key)
                  slot = i;
            if (slot >= 0) begin
               want.became_active = !active_tbl[slot];
               seen_tbl[slot]     = now_ms;
               count_tbl[slot]    = count_tbl[slot] + 1;
               active_tbl[slot]   = 1'b1;
            end else begin
               for (int i = 0; i < ENTRIES; i++)
                  if (slot < 0 && key_tbl[i] == '0)
                     slot = i;
               if (slot < 0)
                  slot = oldest(now_ms, 1'b1);
               if (slot < 0)
                  slot = oldest(now_ms, 1'b0);
               key_tbl[slot]      = key;
               sev_tbl[slot]      = severity_of(code);
               seen_tbl[slot]     = now_ms;
               count_tbl[slot]    = 1;
               active_tbl[slot]   = 1'b1;
               want.new_entry     = 1'b1;
               want.became_active = 1'b1;
            end
            want.slot      = slot[4:0];
            want.hit_count = count_tbl[slot];
         end else begin
            limit = (ttl == '0) ? TTL_DEFAULT : ttl;
            for (int i = 0; i < ENTRIES; i++) begin
               age = now_ms - seen_tbl[i];
               if (key_tbl[i] != '0 && active_tbl[i] && age > limit)
                  active_tbl[i] = 1'b0;
            end
         end
         for (int i = 0; i < ENTRIES; i++) begin
            if (!active_tbl[i])
               continue;
            total++;
            if (sev_tbl[i] > top)
               top = sev_tbl[i];
         end
         want.top_severity = top;
         want.has_problem  = (top >= SEV_WARNING);
         want.active_total = total[5:0];
         expected_q.push_back(want);
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            if (errors <= 100)
               $error("%s: expected %0d, got %0d", name, want, got);
         end
      endfunction

      function void check_response(fault_status_type got);
         fault_status_type want;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 100)
               $error("response with no request outstanding");
            return;
         end
         want = expected_q.pop_front();
         check_field("slot", want.slot, got.slot);
         check_field("new_entry", want.new_entry, got.new_entry);
         check_field("became_active", want.became_active, got.became_active);
         check_field("hit_count", want.hit_count, got.hit_count);
         check_field("top_severity", want.top_severity, got.top_severity);
         check_field("has_problem", want.has_problem, got.has_problem);
         check_field("active_total", want.active_total, got.active_total);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_mode;
   logic [31:0] req_attr;
   logic [31:0] req_code;
   logic [31:0] req_now_ms;
   logic        rsp_strobe;
   logic [4:0]  rsp_slot;
   logic        rsp_new_entry;
   logic        rsp_became_active;
   logic [31:0] rsp_hit_count;
   logic [2:0]  rsp_top_severity;
   logic        rsp_has_problem;
   logic [5:0]  rsp_active_total;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_data;

   fault_table_scoreboard sb;

   fault_event_table_with_aging_unit uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_attr          (req_attr),
      .req_code          (req_code),
      .req_now_ms        (req_now_ms),
      .rsp_strobe        (rsp_strobe),
      .rsp_slot          (rsp_slot),
      .rsp_new_entry     (rsp_new_entry),
      .rsp_became_active (rsp_became_active),
      .rsp_hit_count     (rsp_hit_count),
      .rsp_top_severity  (rsp_top_severity),
      .rsp_has_problem   (rsp_has_problem),
      .rsp_active_total  (rsp_active_total),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // response monitor: strobe is a one-cycle pulse, taken at the edge ending it
   // an unknown strobe counts as a response so that it cannot slip by
   always @(posedge clock) begin
      if (!reset && rsp_strobe !== 1'b0)
         sb.check_response({rsp_slot, rsp_new_entry, rsp_became_active, rsp_hit_count,
                            rsp_top_severity, rsp_has_problem, rsp_active_total});
   end

   // drive one request and hold it until the block takes it
   task automatic issue(input logic mode, input logic [31:0] attr, input logic [31:0] code,
                        input logic [31:0] now_ms);
      @(negedge clock);
      start      <= 1'b1;
      req_mode   <= mode;
      req_attr   <= attr;
      req_code   <= code;
      req_now_ms <= now_ms;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_request(mode, attr, code, now_ms);
   endtask

   task automatic report(input logic [31:0] attr, input logic [31:0] code,
                         input logic [31:0] now_ms);
      issue(MODE_REPORT, attr, code, now_ms);
   endtask

   task automatic tick(input logic [31:0] now_ms);
      issue(MODE_TICK, $urandom, $urandom, now_ms);
   endtask

   // sender idle burst; optionally let the block go idle first so the gap
   // lands after busy falls instead of inside the table walk
   task automatic sender_gap(input int cycles, input bit after_busy);
      @(negedge clock);
      start <= 1'b0;
      if (after_busy)
         while (busy !== 1'b0) @(posedge clock);
      repeat (cycles - 1) @(negedge clock);
   endtask

   // stop sending and wait for every response still owed
   task automatic settle();
      sender_gap(1, 1'b0);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // ttl write, only issued with the block idle
   task automatic write_ttl(input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.set_ttl(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] severity_field();
      case ($urandom_range(0, 5))
         0:       return CODE_FATAL;
         1:       return CODE_ERROR;
         2:       return CODE_WARNING;
         3:       return CODE_INFO;
         4:       return 16'($urandom_range(5, 16'hFFFF));
         default: return 16'h0000;
      endcase
   endfunction

   function automatic logic [31:0] attr_value();
      case ($urandom_range(0, 9))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // directed part under the reset ttl of 20000
   task automatic directed_checks();
      // zero key on an empty table: hit on slot 0, then again
      report(32'h0, 32'h0, 32'd0);
      report(32'h0, 32'h0, 32'd5);
      // real key takes slot 0 even though it is active, since its key is zero
      report(32'h0000_0000, {CODE_FATAL, 16'h0000}, 32'd10);
      report(32'hFFFF_FFFF, {CODE_ERROR, 16'hFFFF}, 32'd20);
      report(32'h1234_5678, {CODE_WARNING, 16'h0001}, 32'd30);
      report(32'h0000_0001, {CODE_INFO, 16'h8000}, 32'd40);
      report(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd50);
      report(32'h0000_0000, {16'd5, 16'h0000}, 32'd60);
      // repeat of an active key
      report(32'hFFFF_FFFF, {CODE_ERROR, 16'hFFFF}, 32'd70);
      // age equal to ttl keeps the entry, one more ms expires it
      tick(32'd20010);
      tick(32'd20011);
      // zero key again, lands on the next empty slot
      report(32'h0, 32'h0, 32'd20020);
      // far jump: everything expires except the active zero-key slot
      tick(32'hFFFF_FFF0);
      // reactivate an expired key, then tick across the wrap
      report(32'h0000_0000, {CODE_FATAL, 16'h0000}, 32'hFFFF_FFF0);
      tick(32'h0000_0010);
      report(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0010);
      // eight new keys at one timestamp, placed in the next empty slots
      for (int i = 0; i < 8; i++)
         report(32'hA5A5_0000 + i, {CODE_WARNING, 16'(i)}, 32'h0000_0020);
   endtask

   // one ttl setting, a key pool of random size, mostly reports from the pool
   task automatic run_phase(input logic [31:0] ttl_value, input int count, input bit with_gaps);
      logic [31:0] pool_attr[48];
      logic [31:0] pool_code[48];
      int          pool_n;
      int          pick;
      int          roll;
      logic [31:0] limit;
      logic [31:0] now_ms;
      settle();
      write_ttl(ttl_value);
      limit  = (ttl_value == '0) ? TTL_DEFAULT : ttl_value;
      pool_n = $urandom_range(6, 48);
      for (int i = 0; i < pool_n; i++) begin
         pool_attr[i]        = attr_value();
         pool_code[i]        = $urandom;
         pool_code[i][31:16] = severity_field();
         if ($urandom_range(0, 15) == 0) begin
            pool_attr[i] = '0;
            pool_code[i] = '0;
         end
      end
      // start somewhere random, often just short of the wrap
      if ($urandom_range(0, 1))
         now_ms = 32'hFFFF_FFFF - $urandom_range(0, 50000);
      else
         now_ms = $urandom;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         // step 0 now and then so entries share a timestamp
         if ($urandom_range(0, 9) != 0)
            now_ms = now_ms + $urandom_range(0, (limit >> 3) + 1);
         if (roll < 3)
            now_ms = $urandom;
         if (roll < 20) begin
            now_ms = now_ms + $urandom_range(0, limit);
            tick(now_ms);
         end else if (roll < 28) begin
            report($urandom, $urandom, now_ms);
         end else begin
            pick = $urandom_range(0, pool_n - 1);
            report(pool_attr[pick], pool_code[pick], now_ms);
         end
         if (with_gaps && $urandom_range(0, 3) == 0)
            sender_gap($urandom_range(1, 16), $urandom_range(0, 1));
      end
   endtask

   // main sequence
   initial begin
      sb         = new();
      reset      = 1'b1;
      start      = 1'b0;
      req_mode   = MODE_REPORT;
      req_attr   = '0;
      req_code   = '0;
      req_now_ms = '0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed_checks();

      // ttl extremes, tiny and small ttls, the default written back, and a random one
      run_phase(32'h0000_0000, 250, 1'b1);
      run_phase(32'hFFFF_FFFF, 250, 1'b1);
      run_phase(32'h0000_0001, 250, 1'b1);
      run_phase(32'd300, 250, 1'b1);
      run_phase(TTL_DEFAULT, 250, 1'b1);
      // last stretch back to back, no idling
      run_phase($urandom_range(1000, 200000), 250, 1'b0);

      settle();
      repeat (40) @(posedge clock);
      if (sb.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #8_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

### filelist.f
hdl/fevt_pkg.sv
hdl/fevt_eval.sv
hdl/fevt_store.sv
hdl/fault_event_table_with_aging_unit.sv
bench/tb.sv
